// ===== rtl/core/sha256_pkg.sv =====
// SHA-256 core package: payload types, controller types, constants and round table.
`timescale 1ns / 1ps
package sha256_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word_0;
      logic [31:0] digest_word_1;
      logic [31:0] digest_word_2;
      logic [31:0] digest_word_3;
      logic [31:0] digest_word_4;
      logic [31:0] digest_word_5;
      logic [31:0] digest_word_6;
      logic [31:0] digest_word_7;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_UPDATE,
      ST_PAD,
      ST_OUTPUT
   } ctrl_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic put_byte;     // pack req byte into block
      logic pad_first;    // write 0x80, zero fill
      logic clear_low;    // clear words 0..13
      logic write_length; // words 14/15 = bit length
      logic start_round;  // load working vars from chaining value
      logic do_round;     // run one round
      logic update_cv;    // add working vars into chaining value
      logic reset_cv;     // restore initial value, clear count
      logic load_digest;  // capture digest into output register
   } dp_cmd_type;

   typedef struct packed {
      logic       block_full; // current byte goes to position 63
      logic       last_round; // round counter at 63
      logic       two_blocks; // pad position at least 56
   } dp_status_type;

   localparam int unsigned RoundCount = 64;
   localparam logic [7:0]  PadByte    = 8'h80;
   localparam logic [5:0]  LengthPos  = 6'd56;

   localparam logic [31:0] InitValue [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ===== rtl/core/sha256_message_digest_core.sv =====
// Sequence: each accepted byte is packed into the block buffer; a byte that fills a block starts
// the rounds on the single shared round unit, then an update of the chaining value. Ending a
// message adds a pad step and one or two padded blocks of rounds and update, then a load of the
// digest register, which waits while an earlier digest is still not accepted. No byte is taken
// while a block is in its rounds, update, padding or output. Reset is synchronous,
// active high, and restores the initial hash value with a zero byte count.
`timescale 1ns / 1ps
module sha256_message_digest_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sha256_pkg::req_payload_type req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sha256_pkg::rsp_payload_type rsp_data
);

   sha256_pkg::dp_cmd_type    cmd;
   sha256_pkg::dp_status_type status;

   sha256_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sha256_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .data_byte (req_data.data_byte),
      .cmd       (cmd),
      .status    (status),
      .digest    (rsp_data)
   );

endmodule

// ===== rtl/core/sha256_ctrl.sv =====
// SHA-256 controller: sequences byte intake, rounds, padding and digest output.
`timescale 1ns / 1ps
module sha256_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sha256_pkg::req_payload_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  sha256_pkg::dp_status_type  status,
   output sha256_pkg::dp_cmd_type     cmd
);

   sha256_pkg::ctrl_state_type state_ff, state_in;
   logic final_ff, final_in;   // current block is a padding block
   logic second_ff, second_in; // length still needs a second block
   logic out_ff, out_in;       // digest held in output register

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sha256_pkg::ST_IDLE;
         final_ff  <= 1'b0;
         second_ff <= 1'b0;
         out_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         final_ff  <= final_in;
         second_ff <= second_in;
         out_ff    <= out_in;
      end
   end

   assign rsp_valid = out_ff;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      final_in  = final_ff;
      second_in = second_ff;
      out_in    = out_ff;
      cmd       = '0;
      req_ready = 1'b0;
      if (out_ff && rsp_ready) begin
         out_in = 1'b0;
      end
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.put_byte = req_data.byte_valid;
               if (req_data.byte_valid && status.block_full) begin
                  cmd.start_round = 1'b1;
                  final_in        = 1'b0;
                  state_in        = sha256_pkg::ST_ROUND;
                  second_in       = req_data.last;
               end else if (req_data.last) begin
                  state_in = sha256_pkg::ST_PAD;
               end
            end
         end
         sha256_pkg::ST_ROUND: begin
            cmd.do_round = 1'b1;
            if (status.last_round) begin
               state_in = sha256_pkg::ST_UPDATE;
            end
         end
         sha256_pkg::ST_UPDATE: begin
            cmd.update_cv = 1'b1;
            if (final_ff && !second_ff) begin
               state_in = sha256_pkg::ST_OUTPUT;
            end else if (final_ff) begin
               // second padding block: zeros then length
               cmd.clear_low    = 1'b1;
               cmd.write_length = 1'b1;
               second_in        = 1'b0;
               state_in         = sha256_pkg::ST_ROUND;
               cmd.start_round  = 1'b0;
            end else if (second_ff) begin
               state_in = sha256_pkg::ST_PAD;
            end else begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         sha256_pkg::ST_PAD: begin
            cmd.pad_first   = 1'b1;
            cmd.start_round = 1'b1;
            final_in        = 1'b1;
            second_in       = status.two_blocks;
            cmd.write_length = !status.two_blocks;
            state_in        = sha256_pkg::ST_ROUND;
         end
         sha256_pkg::ST_OUTPUT: begin
            if (!out_ff || rsp_ready) begin
               cmd.load_digest = 1'b1;
               cmd.reset_cv    = 1'b1;
               out_in          = 1'b1;
               state_in        = sha256_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha256_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/sha256_datapath.sv =====
// SHA-256 datapath: block buffer, schedule window, round unit and chaining value.
`timescale 1ns / 1ps
module sha256_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [7:0]                  data_byte,
   input  sha256_pkg::dp_cmd_type      cmd,
   output sha256_pkg::dp_status_type   status,
   output sha256_pkg::rsp_payload_type digest
);

   logic [31:0] blk_ff [16];
   logic [31:0] blk_in [16];
   logic [31:0] var_ff [8];
   logic [31:0] var_in [8];
   logic [31:0] cv_ff [8];
   logic [31:0] cv_in [8];
   logic [63:0] count_ff, count_in;
   logic [5:0]  round_ff, round_in;
   sha256_pkg::rsp_payload_type digest_ff, digest_in;

   logic [5:0]  pos;
   logic [3:0]  widx;
   logic [1:0]  boff;
   logic [31:0] w, s0, s1, big0, big1, ch, maj, t1, t2;
   logic [31:0] x2, x15, x7, x16;
   logic [63:0] bits;

   assign pos  = count_ff[5:0];
   assign widx = pos[5:2];
   assign boff = pos[1:0];
   assign bits = {count_ff[60:0], 3'b000};

   assign status.block_full = (pos == 6'd63);
   assign status.last_round = (round_ff == 6'(sha256_pkg::RoundCount - 1));
   assign status.two_blocks = (pos >= sha256_pkg::LengthPos);
   assign digest = digest_ff;

   // Schedule: block buffer acts as the rolling 16-word window
   assign x2  = blk_ff[4'(round_ff - 6'd2)];
   assign x15 = blk_ff[4'(round_ff - 6'd15)];
   assign x7  = blk_ff[4'(round_ff - 6'd7)];
   assign x16 = blk_ff[round_ff[3:0]];
   assign s1  = sha256_pkg::rotr(x2, 17) ^ sha256_pkg::rotr(x2, 19) ^ (x2 >> 10);
   assign s0  = sha256_pkg::rotr(x15, 7) ^ sha256_pkg::rotr(x15, 18) ^ (x15 >> 3);
   assign w   = (round_ff < 6'd16) ? x16 : (s1 + x7 + s0 + x16);

   // Round function
   assign big1 = sha256_pkg::rotr(var_ff[4], 6) ^ sha256_pkg::rotr(var_ff[4], 11)
               ^ sha256_pkg::rotr(var_ff[4], 25);
   assign ch   = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
   assign big0 = sha256_pkg::rotr(var_ff[0], 2) ^ sha256_pkg::rotr(var_ff[0], 13)
               ^ sha256_pkg::rotr(var_ff[0], 22);
   assign maj  = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
   assign t1   = var_ff[7] + big1 + ch + sha256_pkg::RoundConst[round_ff] + w;
   assign t2   = big0 + maj;

   always_comb begin
      blk_in    = blk_ff;
      var_in    = var_ff;
      cv_in     = cv_ff;
      count_in  = count_ff;
      round_in  = round_ff;
      digest_in = digest_ff;
      // Pack one message byte
      if (cmd.put_byte) begin
         blk_in[widx] = (boff == 2'd0) ? {24'd0, data_byte} : {blk_ff[widx][23:0], data_byte};
         count_in     = count_ff + 64'd1;
      end
      // Append pad byte, shift into place and zero the tail
      if (cmd.pad_first) begin
         for (int i = 0; i < 16; i++) begin
            if (4'(i) == widx) begin
               case (boff)
                  2'd0: blk_in[i] = {sha256_pkg::PadByte, 24'd0};
                  2'd1: blk_in[i] = {blk_ff[i][7:0], sha256_pkg::PadByte, 16'd0};
                  2'd2: blk_in[i] = {blk_ff[i][15:0], sha256_pkg::PadByte, 8'd0};
                  default: blk_in[i] = {blk_ff[i][23:0], sha256_pkg::PadByte};
               endcase
            end else if (4'(i) > widx) begin
               blk_in[i] = '0;
            end
         end
      end
      if (cmd.clear_low) begin
         for (int i = 0; i < 14; i++) begin
            blk_in[i] = '0;
         end
      end
      if (cmd.write_length) begin
         blk_in[14] = bits[63:32];
         blk_in[15] = bits[31:0];
      end
      // Fold round result into chaining value
      if (cmd.update_cv) begin
         for (int i = 0; i < 8; i++) begin
            cv_in[i] = cv_ff[i] + var_ff[i];
         end
      end
      // Load working variables from the new chaining value
      if (cmd.start_round || cmd.clear_low) begin
         var_in   = cv_in;
         round_in = '0;
      end
      // One round
      if (cmd.do_round) begin
         blk_in[round_ff[3:0]] = w;
         var_in[7] = var_ff[6];
         var_in[6] = var_ff[5];
         var_in[5] = var_ff[4];
         var_in[4] = var_ff[3] + t1;
         var_in[3] = var_ff[2];
         var_in[2] = var_ff[1];
         var_in[1] = var_ff[0];
         var_in[0] = t1 + t2;
         round_in  = round_ff + 6'd1;
      end
      if (cmd.load_digest) begin
         digest_in = {cv_ff[0], cv_ff[1], cv_ff[2], cv_ff[3],
                      cv_ff[4], cv_ff[5], cv_ff[6], cv_ff[7]};
      end
      if (cmd.reset_cv) begin
         cv_in    = sha256_pkg::InitValue;
         count_in = '0;
      end
   end

   // Hold payload state
   always_ff @(posedge clock) begin
      blk_ff    <= blk_in;
      var_ff    <= var_in;
      digest_ff <= digest_in;
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff    <= sha256_pkg::InitValue;
         count_ff <= '0;
         round_ff <= '0;
      end else begin
         cv_ff    <= cv_in;
         count_ff <= count_in;
         round_ff <= round_in;
      end
   end

endmodule
